// ===== hw/rtl/nwa_pkg.sv =====
package nwa_pkg;

   localparam int unsigned MAX_BLOCK_SAMPLES_DEF = 65535;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [1:0] CSR_COMP_LEVEL   = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_16BIT = 2'd1;
   localparam logic [1:0] CSR_STEREO       = 2'd2;

   localparam logic [1:0] COMP_LEVEL_RST   = 2'd2;
   localparam logic       SAMPLE_16BIT_RST = 1'b1;
   localparam logic       STEREO_RST       = 1'b1;

   typedef enum logic [1:0] {
      OP_START,
      OP_BYTE,
      OP_END
   } nwa_op_type;

   typedef struct packed {
      nwa_op_type  op;
      logic [7:0]  data;
      logic [15:0] count;
   } nwa_item_type;

endpackage

// ===== hw/rtl/nwa_front.sv =====
module nwa_front #(
   parameter int unsigned MAX_BLOCK_SAMPLES = nwa_pkg::MAX_BLOCK_SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_data_byte,
   input  logic [15:0]           req_block_samples,
   output logic                  push_valid,
   input  logic                  push_ready,
   output nwa_pkg::nwa_item_type push_item
);

   logic                  vld_ff, vld_in;
   nwa_pkg::nwa_item_type item_ff, item_in;
   nwa_pkg::nwa_op_type   op;
   logic                  keep;
   logic                  take;
   logic [15:0]           count_clamped;

   assign req_ready = !vld_ff || push_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      keep = 1'b1;
      op   = nwa_pkg::OP_BYTE;
      case (req_kind)
         nwa_pkg::KIND_START: op = nwa_pkg::OP_START;
         nwa_pkg::KIND_BYTE:  op = nwa_pkg::OP_BYTE;
         nwa_pkg::KIND_END:   op = nwa_pkg::OP_END;
         default:             keep = 1'b0;
      endcase
      count_clamped = (req_block_samples > 16'(MAX_BLOCK_SAMPLES)) ?
                      16'(MAX_BLOCK_SAMPLES) : req_block_samples;
   end

   // undefined kinds are dropped here and never reach the queue
   assign vld_in  = take ? keep : (vld_ff && !push_ready);

   always_comb begin
      item_in = item_ff;
      if (take) begin
         item_in.op    = op;
         item_in.data  = req_data_byte;
         item_in.count = count_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign push_valid = vld_ff;
   assign push_item  = item_ff;

endmodule

// ===== hw/rtl/nwa_queue.sv =====
module nwa_queue #(
   parameter int unsigned DEPTH = nwa_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  nwa_pkg::nwa_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output nwa_pkg::nwa_item_type pop_item
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   nwa_pkg::nwa_item_type mem_ff [DEPTH];
   logic [AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic                  push, pop;

   assign push_ready = (fill_ff != CW'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      fill_in = fill_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/nwa_back.sv =====
module nwa_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [1:0]            csr_data,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  nwa_pkg::nwa_item_type pop_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_sample_bits,
   output logic                  rsp_channel,
   output logic                  rsp_sample_valid,
   output logic                  rsp_block_done,
   output logic                  rsp_truncated,
   output logic                  rsp_run_last
);

   typedef enum logic {
      ST_FETCH,
      ST_DECODE
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_DECODE,
      PH_DONE
   } phase_type;

   // 11 leftover bits plus one new byte
   localparam int unsigned RES_W = 19;

   function automatic logic [31:0] apply_delta(logic [31:0] acc, logic [7:0] v,
                                               logic [3:0] width, logic [3:0] sh);
      logic [2:0]  sidx;
      logic [7:0]  mmask;
      logic [31:0] mag;
      sidx  = 3'(width - 4'd1);
      mmask = (8'd1 << sidx) - 8'd1;
      mag   = {24'd0, v & mmask} << sh;
      return v[sidx] ? (acc - mag) : (acc + mag);
   endfunction

   function automatic logic [3:0] code_need(logic [RES_W-1:0] res, logic [3:0] bits8,
                                            logic [3:0] bits5);
      logic [3:0] need;
      case (res[2:0])
         3'd7:    need = res[3] ? 4'd4 : (4'd4 + bits8);
         3'd0:    need = 4'd3;
         default: need = 4'd3 + bits5;
      endcase
      return need;
   endfunction

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [1:0]       comp_level_ff, comp_level_in;
   logic             sample16_ff, sample16_in;
   logic             stereo_ff, stereo_in;
   logic [31:0]      acc_l_ff, acc_l_in;
   logic [31:0]      acc_r_ff, acc_r_in;
   logic             ch_ff, ch_in;
   logic [RES_W-1:0] res_ff, res_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [15:0]      samples_ff, samples_in;
   logic [2:0]       hdr_ff, hdr_in;
   logic [1:0]       run_cnt_ff, run_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_bits_ff, rsp_bits_in;
   logic             rsp_ch_ff, rsp_ch_in;
   logic             rsp_sv_ff, rsp_sv_in;
   logic             rsp_done_ff, rsp_done_in;
   logic             rsp_trunc_ff, rsp_trunc_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_ready;
   logic [3:0]       bits8, bits5;
   logic [3:0]       need, need_next;
   logic             code_ok, ok_next, last, done;
   logic [31:0]      acc_cur, acc_new;
   logic [RES_W-1:0] res_sh;
   logic [4:0]       cnt_sh;
   logic [15:0]      sl_dec;
   logic [2:0]       hdr_n, hdr_next, hdr_len;
   logic [15:0]      hdr_samples;
   logic             hdr_sel;
   logic [31:0]      hdr_prev, hdr_val;
   logic             do_header;

   assign csr_ready = 1'b1;
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign bits8     = 4'd8 - {2'b0, comp_level_ff};
   assign bits5     = 4'd5 - {2'b0, comp_level_ff};

   // one code step from the reservoir
   always_comb begin
      acc_cur = ch_ff ? acc_r_ff : acc_l_ff;
      need    = code_need(res_ff, bits8, bits5);
      code_ok = ({1'b0, need} <= cnt_ff);
      case (res_ff[2:0])
         3'd7: begin
            acc_new = res_ff[3] ? 32'd0 :
                      apply_delta(acc_cur, res_ff[11:4], bits8, 4'd9 + {2'b0, comp_level_ff});
         end
         3'd0: acc_new = acc_cur;
         default: begin
            acc_new = apply_delta(acc_cur, {3'b0, res_ff[7:3]}, bits5,
                                  4'd2 + {1'b0, res_ff[2:0]} + {2'b0, comp_level_ff});
         end
      endcase
      res_sh    = res_ff >> need;
      cnt_sh    = cnt_ff - {1'b0, need};
      need_next = code_need(res_sh, bits8, bits5);
      ok_next   = ({1'b0, need_next} <= cnt_sh);
      sl_dec    = samples_ff - 16'd1;
      done      = (sl_dec == 16'd0);
      last      = done || (run_cnt_ff == 2'd3) || !ok_next;
   end

   // start value bytes
   always_comb begin
      hdr_n       = (pop_item.op == nwa_pkg::OP_START) ? 3'd0 : hdr_ff;
      hdr_samples = (pop_item.op == nwa_pkg::OP_START) ? pop_item.count : samples_ff;
      hdr_next    = hdr_n + 3'd1;
      hdr_sel     = sample16_ff ? hdr_n[1] : hdr_n[0];
      hdr_prev    = hdr_sel ? acc_r_ff : acc_l_ff;
      if (sample16_ff) begin
         hdr_val = hdr_n[0] ? {{16{pop_item.data[7]}}, pop_item.data, hdr_prev[7:0]} :
                              {24'd0, pop_item.data};
         hdr_len = stereo_ff ? 3'd4 : 3'd2;
      end else begin
         hdr_val = {{24{pop_item.data[7]}}, pop_item.data};
         hdr_len = stereo_ff ? 3'd2 : 3'd1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      comp_level_in = comp_level_ff;
      sample16_in   = sample16_ff;
      stereo_in     = stereo_ff;
      acc_l_in      = acc_l_ff;
      acc_r_in      = acc_r_ff;
      ch_in         = ch_ff;
      res_in        = res_ff;
      cnt_in        = cnt_ff;
      samples_in    = samples_ff;
      hdr_in        = hdr_ff;
      run_cnt_in    = run_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_bits_in   = rsp_bits_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_sv_in     = rsp_sv_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_trunc_in  = rsp_trunc_ff;
      rsp_last_in   = rsp_last_ff;
      pop_ready     = 1'b0;
      do_header     = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            nwa_pkg::CSR_COMP_LEVEL:   comp_level_in = csr_data;
            nwa_pkg::CSR_SAMPLE_16BIT: sample16_in = csr_data[0];
            nwa_pkg::CSR_STEREO:       stereo_in = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_FETCH: begin
            if (pop_valid && out_ready) begin
               pop_ready = 1'b1;
               case (pop_item.op)
                  nwa_pkg::OP_START: begin
                     samples_in = pop_item.count;
                     res_in     = '0;
                     cnt_in     = '0;
                     ch_in      = 1'b0;
                     phase_in   = PH_HEADER;
                     do_header  = 1'b1;
                  end
                  nwa_pkg::OP_BYTE: begin
                     if (phase_ff == PH_HEADER) begin
                        do_header = 1'b1;
                     end else if (phase_ff == PH_DECODE) begin
                        res_in     = res_ff | (RES_W'({11'd0, pop_item.data}) << cnt_ff);
                        cnt_in     = cnt_ff + 5'd8;
                        run_cnt_in = '0;
                        state_in   = ST_DECODE;
                     end
                  end
                  nwa_pkg::OP_END: begin
                     if (phase_ff == PH_HEADER || phase_ff == PH_DECODE) begin
                        rsp_valid_in = 1'b1;
                        rsp_bits_in  = '0;
                        rsp_ch_in    = 1'b0;
                        rsp_sv_in    = 1'b0;
                        rsp_done_in  = 1'b1;
                        rsp_trunc_in = (samples_ff != 16'd0);
                        rsp_last_in  = 1'b1;
                     end
                     phase_in = PH_IDLE;
                     res_in   = '0;
                     cnt_in   = '0;
                  end
                  default: ;
               endcase

               if (do_header) begin
                  if (hdr_sel) acc_r_in = hdr_val;
                  else acc_l_in = hdr_val;
                  hdr_in = hdr_next;
                  if (hdr_next >= hdr_len) begin
                     phase_in = PH_DECODE;
                     // empty block closes as soon as its start values are in
                     if (hdr_samples == 16'd0) begin
                        phase_in     = PH_DONE;
                        rsp_valid_in = 1'b1;
                        rsp_bits_in  = '0;
                        rsp_ch_in    = 1'b0;
                        rsp_sv_in    = 1'b0;
                        rsp_done_in  = 1'b1;
                        rsp_trunc_in = 1'b0;
                        rsp_last_in  = 1'b1;
                     end
                  end
               end
            end
         end
         ST_DECODE: begin
            if (out_ready) begin
               if (!code_ok) begin
                  state_in = ST_FETCH;
               end else begin
                  if (ch_ff) acc_r_in = acc_new;
                  else acc_l_in = acc_new;
                  res_in       = res_sh;
                  cnt_in       = cnt_sh;
                  samples_in   = sl_dec;
                  run_cnt_in   = run_cnt_ff + 2'd1;
                  rsp_valid_in = 1'b1;
                  rsp_bits_in  = sample16_ff ? acc_new[15:0] : {8'd0, acc_new[7:0]};
                  rsp_ch_in    = ch_ff;
                  rsp_sv_in    = 1'b1;
                  rsp_done_in  = done;
                  rsp_trunc_in = 1'b0;
                  rsp_last_in  = last;
                  if (stereo_ff) ch_in = !ch_ff;
                  if (done) phase_in = PH_DONE;
                  if (last) state_in = ST_FETCH;
               end
            end
         end
         default: state_in = ST_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FETCH;
         phase_ff      <= PH_IDLE;
         comp_level_ff <= nwa_pkg::COMP_LEVEL_RST;
         sample16_ff   <= nwa_pkg::SAMPLE_16BIT_RST;
         stereo_ff     <= nwa_pkg::STEREO_RST;
         acc_l_ff      <= '0;
         acc_r_ff      <= '0;
         ch_ff         <= 1'b0;
         res_ff        <= '0;
         cnt_ff        <= '0;
         samples_ff    <= '0;
         hdr_ff        <= '0;
         run_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         comp_level_ff <= comp_level_in;
         sample16_ff   <= sample16_in;
         stereo_ff     <= stereo_in;
         acc_l_ff      <= acc_l_in;
         acc_r_ff      <= acc_r_in;
         ch_ff         <= ch_in;
         res_ff        <= res_in;
         cnt_ff        <= cnt_in;
         samples_ff    <= samples_in;
         hdr_ff        <= hdr_in;
         run_cnt_ff    <= run_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_bits_ff  <= rsp_bits_in;
      rsp_ch_ff    <= rsp_ch_in;
      rsp_sv_ff    <= rsp_sv_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_trunc_ff <= rsp_trunc_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_bits  = rsp_bits_ff;
   assign rsp_channel      = rsp_ch_ff;
   assign rsp_sample_valid = rsp_sv_ff;
   assign rsp_block_done   = rsp_done_ff;
   assign rsp_truncated    = rsp_trunc_ff;
   assign rsp_run_last     = rsp_last_ff;

   a_decode_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECODE |-> phase_ff == PH_DECODE)
      else $error("code walk outside decoding phase");

   a_res_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 5'(RES_W))
      else $error("reservoir count overflow");

   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_sv_ff |-> rsp_done_ff && rsp_last_ff)
      else $error("status beat not closing its block");

   a_trunc_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_trunc_ff |-> !rsp_sv_ff)
      else $error("truncated flag on a sample beat");

endmodule

// ===== hw/rtl/nwa_audio_block_decoder_core.sv =====
// Path: an accepted beat passes the front register and the queue to the back end, which
//   registers each start, end or sample result in its output register until it is taken.
// Throughput: one input beat per cycle into a small queue while it has room; the decoder
//   fetches a byte, then decodes up to 4 samples from it while the output is not held.
// Reset: synchronous, active high; clears queue, phase and accumulators and sets
//   comp_level 2, 16-bit samples, stereo.
module nwa_audio_block_decoder_core #(
   parameter int unsigned MAX_BLOCK_SAMPLES = nwa_pkg::MAX_BLOCK_SAMPLES_DEF,
   parameter int unsigned QUEUE_DEPTH       = nwa_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_block_samples,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_sample_bits,
   output logic        rsp_channel,
   output logic        rsp_sample_valid,
   output logic        rsp_block_done,
   output logic        rsp_truncated,
   output logic        rsp_run_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_data
);

   logic                  push_valid, push_ready;
   nwa_pkg::nwa_item_type push_item;
   logic                  pop_valid, pop_ready;
   nwa_pkg::nwa_item_type pop_item;

   nwa_front #(
      .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_data_byte     (req_data_byte),
      .req_block_samples (req_block_samples),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_item         (push_item)
   );

   nwa_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   nwa_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_item         (pop_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_bits  (rsp_sample_bits),
      .rsp_channel      (rsp_channel),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_block_done   (rsp_block_done),
      .rsp_truncated    (rsp_truncated),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam logic [1:0] KIND_NONE   = 2'd3;   // unused kind, decoder drops it
   localparam int         SETTLE      = 40;
   localparam int         CYCLE_LIMIT = 300000;
   localparam int         PHASE_ITEMS = 20;

   typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_DECODE, PH_DONE} phase_type;

   typedef struct packed {
      logic [15:0] bits;
      logic        ch;
      logic        smp;
      logic        done;
      logic        trunc;
      logic        last;
   } beat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [15:0] count;
      logic        typed;
      logic        has_beat;
      beat_type    beat;
   } row_type;

   typedef struct packed {
      logic [1:0] lvl;
      logic       w16;
      logic       st;
   } cfg_type;

   localparam beat_type NO_BEAT    = '0;
   localparam beat_type DONE_EMPTY = '{16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam beat_type DONE_TRUNC = '{16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
   localparam logic     TYPED = 1'b1;
   localparam logic     MODEL = 1'b0;

   // reset config: level 2, 16-bit, stereo -> four header bytes per block
   row_type plan [26] = '{
      '{nwa_pkg::KIND_END,   8'h00, 16'h0000, TYPED, 1'b0, NO_BEAT},    // end while idle
      '{nwa_pkg::KIND_BYTE,  8'h55, 16'h0000, TYPED, 1'b0, NO_BEAT},    // byte while idle
      '{KIND_NONE,           8'hAA, 16'hFFFF, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_START, 8'h00, 16'h0000, TYPED, 1'b0, NO_BEAT},    // empty block
      '{nwa_pkg::KIND_BYTE,  8'hFF, 16'h0000, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_BYTE,  8'h80, 16'h0000, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_BYTE,  8'h7F, 16'h0000, TYPED, 1'b1, DONE_EMPTY},
      '{nwa_pkg::KIND_BYTE,  8'h55, 16'h0000, TYPED, 1'b0, NO_BEAT},    // after block end
      '{nwa_pkg::KIND_END,   8'h00, 16'h0000, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_START, 8'hFF, 16'hFFFF, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_START, 8'h34, 16'h0008, TYPED, 1'b0, NO_BEAT},    // restart mid-header
      '{nwa_pkg::KIND_BYTE,  8'h12, 16'h0000, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_BYTE,  8'h00, 16'h0000, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_BYTE,  8'h80, 16'h0000, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_BYTE,  8'hFF, 16'h0000, MODEL, 1'b0, NO_BEAT},    // two zeroing codes
      '{nwa_pkg::KIND_BYTE,  8'h00, 16'h0000, MODEL, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_BYTE,  8'h0F, 16'h0000, MODEL, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_BYTE,  8'hA5, 16'h0000, MODEL, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_END,   8'h00, 16'h0000, TYPED, 1'b1, DONE_TRUNC}, // 7 of 8 samples
      '{nwa_pkg::KIND_START, 8'h01, 16'h0002, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_BYTE,  8'hFF, 16'h0000, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_BYTE,  8'h00, 16'h0000, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_BYTE,  8'h80, 16'h0000, TYPED, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_BYTE,  8'h77, 16'h0000, MODEL, 1'b0, NO_BEAT},    // long delta split
      '{nwa_pkg::KIND_BYTE,  8'hE9, 16'h0000, MODEL, 1'b0, NO_BEAT},
      '{nwa_pkg::KIND_END,   8'h00, 16'h0000, TYPED, 1'b0, NO_BEAT}     // block already done
   };

   cfg_type settings [8] = '{
      '{2'd0, 1'b0, 1'b0}, '{2'd3, 1'b1, 1'b1}, '{2'd1, 1'b0, 1'b1}, '{2'd0, 1'b1, 1'b0},
      '{2'd2, 1'b0, 1'b0}, '{2'd1, 1'b1, 1'b1}, '{2'd3, 1'b0, 1'b1}, '{2'd2, 1'b1, 1'b1}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = nwa_pkg::KIND_START;
   logic [7:0]  req_data_byte = '0;
   logic [15:0] req_block_samples = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_sample_bits;
   logic        rsp_channel;
   logic        rsp_sample_valid;
   logic        rsp_block_done;
   logic        rsp_truncated;
   logic        rsp_run_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = nwa_pkg::CSR_COMP_LEVEL;
   logic [1:0]  csr_data = '0;

   // decoder copy: registers and state
   logic [1:0]  cfg_level = nwa_pkg::COMP_LEVEL_RST;
   logic        cfg_16 = nwa_pkg::SAMPLE_16BIT_RST;
   logic        cfg_st = nwa_pkg::STEREO_RST;
   logic [31:0] acc [2] = '{32'd0, 32'd0};
   logic        cur_ch = 1'b0;
   logic [31:0] resv = '0;
   int          resv_cnt = 0;
   logic [15:0] left = '0;
   logic [2:0]  hdr_seen = '0;
   phase_type   phase = PH_IDLE;

   beat_type    decoded_q [$];
   int          errors = 0;
   int          items_in = 0;
   int          beats_out = 0;
   int          cycles = 0;
   bit          no_idle = 1'b0;
   int          hold_cycles = 0;

   nwa_audio_block_decoder_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_data_byte(req_data_byte),
      .req_block_samples(req_block_samples),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_bits(rsp_sample_bits),
      .rsp_channel(rsp_channel),
      .rsp_sample_valid(rsp_sample_valid),
      .rsp_block_done(rsp_block_done),
      .rsp_truncated(rsp_truncated),
      .rsp_run_last(rsp_run_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still pending", cycles,
                  decoded_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic report(input string msg);
      errors++;
      if (errors <= 30)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   function automatic int draw_gap();
      if (no_idle)
         return 0;
      return $urandom_range(0, 1) ? $urandom_range(0, 14) : $urandom_range(0, 2);
   endfunction

   function automatic void push_beat(input logic [15:0] bits, input logic ch,
                                     input logic smp, input logic done, input logic trunc);
      beat_type b;
      b = '{bits, ch, smp, done, trunc, 1'b0};
      decoded_q.push_back(b);
   endfunction

   function automatic int header_len();
      return (cfg_16 ? 2 : 1) * (cfg_st ? 2 : 1);
   endfunction

   function automatic void add_delta(input logic ch, input int unsigned v,
                                     input int unsigned w, input int unsigned sh);
      int unsigned sign, mag;
      sign = 1 << (w - 1);
      mag = (v & (sign - 1)) << sh;
      if ((v & sign) != 0)
         acc[ch] = acc[ch] - mag;
      else
         acc[ch] = acc[ch] + mag;
   endfunction

   function automatic void take_header(input logic [7:0] b);
      logic [2:0]  n;
      logic [15:0] v16;
      n = hdr_seen;
      if (cfg_16) begin
         if (!n[0]) begin
            acc[n[1]] = {24'd0, b};
         end else begin
            v16 = {b, acc[n[1]][7:0]};
            acc[n[1]] = {{16{v16[15]}}, v16};
         end
      end else begin
         acc[n[0]] = {{24{b[7]}}, b};
      end
      hdr_seen = n + 3'd1;
      if (int'(hdr_seen) >= header_len()) begin
         phase = PH_DECODE;
         if (left == 16'd0) begin
            phase = PH_DONE;
            push_beat(16'd0, 1'b0, 1'b0, 1'b1, 1'b0);
         end
      end
   endfunction

   function automatic void take_data(input logic [7:0] b);
      int unsigned lvl, w8, w5, code, need;
      int          n;
      logic        done;
      lvl = cfg_level;
      w8 = 8 - lvl;
      w5 = 5 - lvl;
      n = 0;
      resv = (resv | ({24'd0, b} << resv_cnt)) & 32'h00FF_FFFF;
      resv_cnt += 8;
      while (phase == PH_DECODE && n < 4) begin
         if (resv_cnt < 3)
            break;
         code = resv[2:0];
         if (code == 7) begin
            if (resv_cnt < 4)
               break;
            if (resv[3]) begin
               need = 4;
               acc[cur_ch] = '0;
            end else begin
               need = 4 + w8;
               if (resv_cnt < int'(need))
                  break;
               add_delta(cur_ch, (resv >> 4) & ((1 << w8) - 1), w8, 9 + lvl);
            end
         end else if (code != 0) begin
            need = 3 + w5;
            if (resv_cnt < int'(need))
               break;
            add_delta(cur_ch, (resv >> 3) & ((1 << w5) - 1), w5, 2 + code + lvl);
         end else begin
            need = 3;
         end
         resv = resv >> need;
         resv_cnt -= need;
         left = left - 16'd1;
         done = (left == 16'd0);
         push_beat(cfg_16 ? acc[cur_ch][15:0] : {8'd0, acc[cur_ch][7:0]}, cur_ch,
                   1'b1, done, 1'b0);
         n++;
         if (cfg_st)
            cur_ch = ~cur_ch;
         if (done)
            phase = PH_DONE;
      end
   endfunction

   // advance the decoder copy by one input beat; returns the number of beats queued
   function automatic int run_decoder(input logic [1:0] k, input logic [7:0] b,
                                      input logic [15:0] cnt);
      int       n0, made;
      beat_type t;
      n0 = decoded_q.size();
      case (k)
         nwa_pkg::KIND_START: begin
            left = (int'(cnt) > nwa_pkg::MAX_BLOCK_SAMPLES_DEF) ?
                   16'(nwa_pkg::MAX_BLOCK_SAMPLES_DEF) : cnt;
            hdr_seen = '0;
            resv = '0;
            resv_cnt = 0;
            cur_ch = 1'b0;
            phase = PH_HEADER;
            take_header(b);
         end
         nwa_pkg::KIND_BYTE: begin
            if (phase == PH_HEADER)
               take_header(b);
            else if (phase == PH_DECODE)
               take_data(b);
         end
         nwa_pkg::KIND_END: begin
            if (phase == PH_HEADER || phase == PH_DECODE)
               push_beat(16'd0, 1'b0, 1'b0, 1'b1, left != 16'd0);
            phase = PH_IDLE;
            resv = '0;
            resv_cnt = 0;
         end
         default: ;
      endcase
      made = decoded_q.size() - n0;
      if (made > 0) begin
         t = decoded_q.pop_back();
         t.last = 1'b1;
         decoded_q.push_back(t);
      end
      return made;
   endfunction

   task automatic send_item(input logic [1:0] k, input logic [7:0] d,
                            input logic [15:0] c, output int made);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_data_byte <= d;
      req_block_samples <= c;
      do @(posedge clock); while (!req_ready);
      items_in++;
      made = run_decoder(k, d, c);
   endtask

   task automatic csr_beat(input logic [1:0] idx, input logic [1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         nwa_pkg::CSR_COMP_LEVEL:   cfg_level = val;
         nwa_pkg::CSR_SAMPLE_16BIT: cfg_16 = val[0];
         default:                   cfg_st = val[0];
      endcase
   endtask

   // wait until every queued beat is out, then let dropped beats clear the pipe
   task automatic drain();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_phase(input int budget);
      int          sent, made, hdr, nbytes, i, pick;
      logic [15:0] cnt;
      logic [1:0]  k;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 7) != 0) begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
               cnt = 16'd0;
            else if (pick == 1)
               cnt = 16'($urandom);
            else
               cnt = 16'($urandom_range(1, 24));
            hdr = header_len();
            send_item(nwa_pkg::KIND_START, 8'($urandom), cnt, made);
            for (i = 1; i < hdr; i++)
               send_item(nwa_pkg::KIND_BYTE, 8'($urandom), 16'($urandom), made);
            nbytes = $urandom_range(0, 14);
            for (i = 0; i < nbytes; i++)
               send_item(nwa_pkg::KIND_BYTE, 8'($urandom), 16'($urandom), made);
            sent += hdr + nbytes;
            // some blocks are left open and cut off by the next start
            if ($urandom_range(0, 3) != 0) begin
               send_item(nwa_pkg::KIND_END, 8'($urandom), 16'($urandom), made);
               sent++;
            end
         end else begin
            k = 2'($urandom_range(0, 3));
            send_item(k, 8'($urandom), 16'($urandom), made);
            if (k != KIND_NONE)
               sent++;
         end
      end
   endtask

   initial begin : rsp_side
      int stall;
      forever begin
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = draw_gap();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : rsp_check
      beat_type got, want;
      string    diff;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_sample_bits, rsp_channel, rsp_sample_valid, rsp_block_done,
                 rsp_truncated, rsp_run_last};
         beats_out++;
         if (decoded_q.size() == 0) begin
            report($sformatf("unexpected beat %h", got));
         end else begin
            want = decoded_q.pop_front();
            diff = "";
            if (got.bits != want.bits)   diff = {diff, " sample_bits"};
            if (got.ch != want.ch)       diff = {diff, " channel"};
            if (got.smp != want.smp)     diff = {diff, " sample_valid"};
            if (got.done != want.done)   diff = {diff, " block_done"};
            if (got.trunc != want.trunc) diff = {diff, " truncated"};
            if (got.last != want.last)   diff = {diff, " run_last"};
            if (diff != "")
               report($sformatf("beat %0d:%s differ, got %h want %h", beats_out, diff,
                                got, want));
         end
      end
   end

   initial begin : stimulus
      int made, p;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) begin
         send_item(plan[i].kind, plan[i].data, plan[i].count, made);
         if (plan[i].typed) begin
            repeat (made) void'(decoded_q.pop_back());
            if (plan[i].has_beat)
               decoded_q.push_back(plan[i].beat);
         end
      end
      drain();
      for (p = 0; p < 8; p++) begin
         csr_beat(nwa_pkg::CSR_COMP_LEVEL, settings[p].lvl);
         csr_beat(nwa_pkg::CSR_SAMPLE_16BIT, {1'b0, settings[p].w16});
         csr_beat(nwa_pkg::CSR_STEREO, {1'b0, settings[p].st});
         csr_valid <= 1'b0;
         no_idle = (p == 1 || p == 5);
         if (p == 3)
            hold_cycles = 250;
         random_phase(PHASE_ITEMS);
         drain();
      end
      $display("Run: %0d input beats, directed table plus 8 register settings", items_in);
      $display("     (levels 0-3, 8/16-bit, mono/stereo), %0d result beats checked",
               beats_out);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
